// File: rtl/drs_pkg.sv
// Shared types, register codes and reset constants for the deploy/retract sequencer.
package drs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_DEBOUNCE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALL_DEBOUNCE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_LIMIT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPOOL_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFLATE         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFLATE         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE          = 3'd6;

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_EXT_MOTORS = 3'd1;
   localparam logic [2:0] PH_INFLATE    = 3'd2;
   localparam logic [2:0] PH_EXT_SETTLE = 3'd3;
   localparam logic [2:0] PH_RET_CLEAR  = 3'd4;
   localparam logic [2:0] PH_DEFLATE    = 3'd5;
   localparam logic [2:0] PH_RET_SETTLE = 3'd6;
   localparam logic [2:0] PH_RET_MOTORS = 3'd7;

   localparam logic [4:0] FANS_135 = 5'h15;
   localparam logic [4:0] FANS_35  = 5'h14;
   localparam logic [4:0] FANS_24  = 5'h0A;

   typedef struct packed {
      logic [15:0] button_debounce_ms;
      logic [15:0] hall_debounce_ms;
      logic [7:0]  wheel_pulse_limit;
      logic [7:0]  spool_pulse_limit;
      logic [19:0] inflate_ms;
      logic [19:0] deflate_ms;
      logic [15:0] settle_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      button_debounce_ms: 16'd50,
      hall_debounce_ms:   16'd500,
      wheel_pulse_limit:  8'd12,
      spool_pulse_limit:  8'd11,
      inflate_ms:         20'd35000,
      deflate_ms:         20'd70000,
      settle_ms:          16'd100
   };

   typedef struct packed {
      logic extend_level;
      logic retract_level;
      logic wheel_edge;
      logic spool_edge;
   } item_type;

   typedef struct packed {
      logic       wheel_forward;
      logic       wheel_reverse;
      logic       spool_forward;
      logic       spool_reverse;
      logic [4:0] fan_drive;
      logic       extend_lamp;
      logic       retract_lamp;
      logic       busy_res;
   } result_type;

endpackage

// File: rtl/drs_csr.sv
// Configuration register file of the deploy/retract sequencer.
module drs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [drs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [drs_pkg::CSR_DATA_W-1:0]     csr_data,
   output drs_pkg::cfg_type                   cfg
);
   import drs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BUTTON_DEBOUNCE: cfg_in.button_debounce_ms = csr_data[15:0];
            CSR_HALL_DEBOUNCE:   cfg_in.hall_debounce_ms   = csr_data[15:0];
            CSR_WHEEL_LIMIT:     cfg_in.wheel_pulse_limit  = csr_data[7:0];
            CSR_SPOOL_LIMIT:     cfg_in.spool_pulse_limit  = csr_data[7:0];
            CSR_INFLATE:         cfg_in.inflate_ms         = csr_data[19:0];
            CSR_DEFLATE:         cfg_in.deflate_ms         = csr_data[19:0];
            CSR_SETTLE:          cfg_in.settle_ms          = csr_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/drs_core.sv
// Sequencer state and the one-tick update of timers, counters, lamps and phase.
module drs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  drs_pkg::item_type    item,
   input  drs_pkg::cfg_type     cfg,
   output drs_pkg::result_type  result
);
   import drs_pkg::*;

   // Tick time and debounce stamps.
   logic [31:0] time_ff, time_in;
   logic [31:0] button_time_ff, button_time_in;
   logic [31:0] wheel_time_ff, wheel_time_in;
   logic [31:0] spool_time_ff, spool_time_in;
   // Buttons and lamps.
   logic        extend_prev_ff, extend_prev_in;
   logic        retract_prev_ff, retract_prev_in;
   logic        extend_led_ff, extend_led_in;
   logic        retract_led_ff, retract_led_in;
   // Sequence.
   logic [2:0]  phase_ff, phase_in;
   logic [19:0] phase_timer_ff, phase_timer_in;
   logic [7:0]  wheel_count_ff, wheel_count_in;
   logic [7:0]  spool_count_ff, spool_count_in;
   logic        wheel_run_ff, wheel_run_in;
   logic        spool_run_ff, spool_run_in;
   logic [15:0] wheel_stop_ff, wheel_stop_in;
   logic [15:0] spool_stop_ff, spool_stop_in;
   logic [4:0]  fan_ff, fan_in;
   logic        reverse_ff, reverse_in;

   logic [19:0] timer_inc;
   logic [19:0] stage_len;
   logic        stage_done;
   logic        button_ok;
   logic        extend_change;
   logic        retract_change;

   assign timer_inc = phase_timer_ff + 20'd1;

   always_comb begin
      case (phase_ff)
         PH_INFLATE: stage_len = cfg.inflate_ms;
         PH_DEFLATE: stage_len = cfg.deflate_ms;
         default:    stage_len = {4'd0, cfg.settle_ms};
      endcase
   end

   // A zero-length stage still takes one tick because the timer is bumped first.
   assign stage_done = (timer_inc >= stage_len);

   always_comb begin
      time_in         = time_ff + 32'd1;
      button_time_in  = button_time_ff;
      wheel_time_in   = wheel_time_ff;
      spool_time_in   = spool_time_ff;
      extend_prev_in  = extend_prev_ff;
      retract_prev_in = retract_prev_ff;
      extend_led_in   = extend_led_ff;
      retract_led_in  = retract_led_ff;
      phase_in        = phase_ff;
      phase_timer_in  = phase_timer_ff;
      wheel_count_in  = wheel_count_ff;
      spool_count_in  = spool_count_ff;
      wheel_run_in    = wheel_run_ff;
      spool_run_in    = spool_run_ff;
      wheel_stop_in   = wheel_stop_ff;
      spool_stop_in   = spool_stop_ff;
      fan_in          = fan_ff;
      reverse_in      = reverse_ff;

      // Hall edges are counted and toggle the lamps even while idle.
      if (item.wheel_edge && ((time_in - wheel_time_ff) > {16'd0, cfg.hall_debounce_ms})) begin
         wheel_time_in = time_in;
         if (wheel_count_ff != 8'hFF) begin
            wheel_count_in = wheel_count_ff + 8'd1;
         end
         extend_led_in = ~extend_led_ff;
      end
      if (item.spool_edge && ((time_in - spool_time_ff) > {16'd0, cfg.hall_debounce_ms})) begin
         spool_time_in = time_in;
         if (spool_count_ff != 8'hFF) begin
            spool_count_in = spool_count_ff + 8'd1;
         end
         retract_led_in = ~retract_led_ff;
      end

      unique case (phase_ff) inside
         PH_IDLE: begin
         end
         PH_EXT_MOTORS, PH_RET_MOTORS: begin
            // Each motor stops on its own, one settle time after its limit.
            if (wheel_run_ff && (wheel_count_in >= cfg.wheel_pulse_limit)) begin
               if (wheel_stop_ff != 16'hFFFF) begin
                  wheel_stop_in = wheel_stop_ff + 16'd1;
               end
               if (wheel_stop_in >= cfg.settle_ms) begin
                  wheel_run_in = 1'b0;
               end
            end
            if (spool_run_ff && (spool_count_in >= cfg.spool_pulse_limit)) begin
               if (spool_stop_ff != 16'hFFFF) begin
                  spool_stop_in = spool_stop_ff + 16'd1;
               end
               if (spool_stop_in >= cfg.settle_ms) begin
                  spool_run_in = 1'b0;
               end
            end
            if (!wheel_run_in && !spool_run_in) begin
               phase_timer_in = 20'd0;
               if (phase_ff == PH_EXT_MOTORS) begin
                  fan_in   = fan_ff | FANS_135;
                  phase_in = PH_INFLATE;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_INFLATE, PH_EXT_SETTLE, PH_RET_CLEAR, PH_DEFLATE, PH_RET_SETTLE: begin
            phase_timer_in = stage_done ? 20'd0 : timer_inc;
            if (stage_done) begin
               case (phase_ff)
                  PH_INFLATE: begin
                     fan_in   = fan_ff & ~FANS_35;
                     phase_in = PH_EXT_SETTLE;
                  end
                  PH_RET_CLEAR: begin
                     fan_in   = fan_ff | FANS_24;
                     phase_in = PH_DEFLATE;
                  end
                  PH_DEFLATE: begin
                     fan_in   = fan_ff & ~FANS_24;
                     phase_in = PH_RET_SETTLE;
                  end
                  PH_RET_SETTLE: begin
                     wheel_count_in = 8'd0;
                     spool_count_in = 8'd0;
                     wheel_run_in   = 1'b1;
                     spool_run_in   = 1'b1;
                     wheel_stop_in  = 16'd0;
                     spool_stop_in  = 16'd0;
                     reverse_in     = 1'b1;
                     phase_in       = PH_RET_MOTORS;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Buttons share one stamp, so an accepted extend change blocks retract this tick.
      if (phase_in == PH_IDLE) begin
         if (extend_change) begin
            button_time_in = time_in;
            extend_prev_in = item.extend_level;
            if (!item.extend_level) begin
               if (extend_led_in) begin
                  extend_led_in  = 1'b0;
                  wheel_count_in = 8'd0;
                  spool_count_in = 8'd0;
                  wheel_run_in   = 1'b1;
                  spool_run_in   = 1'b1;
                  wheel_stop_in  = 16'd0;
                  spool_stop_in  = 16'd0;
                  reverse_in     = 1'b0;
                  phase_timer_in = 20'd0;
                  phase_in       = PH_EXT_MOTORS;
               end else begin
                  extend_led_in = 1'b1;
               end
            end
         end else if (retract_change) begin
            button_time_in  = time_in;
            retract_prev_in = item.retract_level;
            if (!item.retract_level) begin
               if (retract_led_in) begin
                  retract_led_in = 1'b0;
                  fan_in         = fan_in & ~FANS_135;
                  phase_timer_in = 20'd0;
                  phase_in       = PH_RET_CLEAR;
               end else begin
                  retract_led_in = 1'b1;
               end
            end
         end
      end
   end

   assign button_ok      = ((time_in - button_time_ff) > {16'd0, cfg.button_debounce_ms});
   assign extend_change  = button_ok && (item.extend_level != extend_prev_ff);
   assign retract_change = button_ok && (item.retract_level != retract_prev_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= 32'd0;
         button_time_ff  <= 32'd0;
         wheel_time_ff   <= 32'd0;
         spool_time_ff   <= 32'd0;
         extend_prev_ff  <= 1'b0;
         retract_prev_ff <= 1'b0;
         extend_led_ff   <= 1'b0;
         retract_led_ff  <= 1'b0;
         phase_ff        <= PH_IDLE;
         phase_timer_ff  <= 20'd0;
         wheel_count_ff  <= 8'd0;
         spool_count_ff  <= 8'd0;
         wheel_run_ff    <= 1'b0;
         spool_run_ff    <= 1'b0;
         wheel_stop_ff   <= 16'd0;
         spool_stop_ff   <= 16'd0;
         fan_ff          <= 5'd0;
         reverse_ff      <= 1'b0;
      end else if (step) begin
         time_ff         <= time_in;
         button_time_ff  <= button_time_in;
         wheel_time_ff   <= wheel_time_in;
         spool_time_ff   <= spool_time_in;
         extend_prev_ff  <= extend_prev_in;
         retract_prev_ff <= retract_prev_in;
         extend_led_ff   <= extend_led_in;
         retract_led_ff  <= retract_led_in;
         phase_ff        <= phase_in;
         phase_timer_ff  <= phase_timer_in;
         wheel_count_ff  <= wheel_count_in;
         spool_count_ff  <= spool_count_in;
         wheel_run_ff    <= wheel_run_in;
         spool_run_ff    <= spool_run_in;
         wheel_stop_ff   <= wheel_stop_in;
         spool_stop_ff   <= spool_stop_in;
         fan_ff          <= fan_in;
         reverse_ff      <= reverse_in;
      end
   end

   assign result.wheel_forward = wheel_run_in && !reverse_in;
   assign result.wheel_reverse = wheel_run_in && reverse_in;
   assign result.spool_forward = spool_run_in && !reverse_in;
   assign result.spool_reverse = spool_run_in && reverse_in;
   assign result.fan_drive     = fan_in;
   assign result.extend_lamp   = extend_led_in;
   assign result.retract_lamp  = retract_led_in;
   assign result.busy_res      = (phase_in != PH_IDLE);

   // Motors only run inside a sequence.
   a_idle_motors_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (!wheel_run_ff && !spool_run_ff))
      else $error("motor running while idle");

   // Fans two and four are on only during the deflate stage.
   a_fans24_deflate: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DEFLATE) |-> (!fan_ff[1] && !fan_ff[3]))
      else $error("fans two or four on outside deflate");

endmodule

// File: rtl/deploy_retract_sequencer.sv
// Top level of the deploy/retract sequencer: channel registers around the tick update.
//
// Usage:
//   One req_ word is one millisecond tick: the two button pin levels (0 = pressed)
//   and the two Hall falling-edge flags seen during that tick. Each accepted word
//   yields exactly one rsp_ word with the relay drives, fan outputs, lamp states
//   and the busy flag as they stand after that tick.
//   A req_ word is taken into the input register; it then updates the sequencer
//   state and its result word lands in the output register, so the result passes
//   through both registers in turn. One word per cycle is sustained while rsp_stall
//   is low; the whole tick update is a single register-to-register pass.
//   When rsp_stall is held, the finished word waits in the output register and
//   one more req_ word is still taken into the input register; req_stall then
//   rises until the output word is taken.
//   Registers are to be written through csr_write/csr_index/csr_data only while no
//   word is in flight, which the block does not enforce; an unknown index is ignored.
//   Synchronous reset empties both registers, clears all sequencer state and
//   loads the default register values.
module deploy_retract_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_extend_level,
   input  logic                            req_retract_level,
   input  logic                            req_wheel_edge,
   input  logic                            req_spool_edge,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_wheel_forward,
   output logic                            rsp_wheel_reverse,
   output logic                            rsp_spool_forward,
   output logic                            rsp_spool_reverse,
   output logic [4:0]                      rsp_fan_drive,
   output logic                            rsp_extend_lamp,
   output logic                            rsp_retract_lamp,
   output logic                            rsp_busy_res,
   input  logic                            csr_write,
   input  logic [drs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [drs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import drs_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   result_type result;
   result_type out_ff;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       req_take;
   logic       step;

   // The held word moves on when the output register is free or being emptied.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.extend_level  <= req_extend_level;
         item_ff.retract_level <= req_retract_level;
         item_ff.wheel_edge    <= req_wheel_edge;
         item_ff.spool_edge    <= req_spool_edge;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   drs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   drs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_wheel_forward = out_ff.wheel_forward;
   assign rsp_wheel_reverse = out_ff.wheel_reverse;
   assign rsp_spool_forward = out_ff.spool_forward;
   assign rsp_spool_reverse = out_ff.spool_reverse;
   assign rsp_fan_drive     = out_ff.fan_drive;
   assign rsp_extend_lamp   = out_ff.extend_lamp;
   assign rsp_retract_lamp  = out_ff.retract_lamp;
   assign rsp_busy_res      = out_ff.busy_res;

   a_step_gives_word: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed word did not reach the output register");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("output word repeated after it was taken");

endmodule
